/* design/pasv_pkg.sv */
// Shared types and character codes for the passive-mode reply address parser.
package pasv_pkg;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_START  = 3'd1,
    PH_SIGN   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4,
    PH_FAIL   = 3'd5
  } phase_e;

  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChNul   = 8'h00;

  localparam logic [2:0] LastOctet  = 3'd3;
  localparam logic [2:0] PortHiIdx  = 3'd4;
  localparam logic [2:0] PortLoIdx  = 3'd5;

  localparam int unsigned AddrW = 32;
  localparam int unsigned PortW = 16;
  localparam int unsigned OutW  = AddrW + PortW;

endpackage

/* design/pasv_reply_address_parser_top.sv */
// A final byte is registered in the input stage, then its result beat in the output register.
// Throughput: one reply byte per cycle; input stalls only while a result
//   beat waits in the output register and another final byte is staged.
// Reset (rst_ni low, asynchronous): parser returns to searching for '(',
//   both stages empty. The four octet registers are not reset; they are only
//   read after being written in the same line.
module pasv_reply_address_parser_top
  import pasv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] reply_byte
  input  logic              s_axis_tlast_i,   // end_of_line
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OutW-1:0]   m_axis_tdata_o,   // [31:0] host_address, [47:32] data_port
  output logic              m_axis_tuser_o    // parse_ok
);

  // input stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // parser state
  phase_e     phase_q, phase_d;
  logic [2:0] field_q, field_d;
  logic       neg_q, neg_d;
  logic [7:0] mag_q, mag_d;
  logic       over_q, over_d;
  logic [15:0] port_q, port_d;
  logic       inv_q, inv_d;
  logic [7:0] octet_q [4];

  // output stage
  logic            out_vld_q;
  logic [OutW-1:0] out_data_q;
  logic            out_ok_q;

  logic            out_free;
  logic            advance;
  logic            oct_we;
  logic [1:0]      oct_idx;
  logic            res_ok;
  logic [OutW-1:0] res_data;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_comb begin
    logic        digit;
    logic        space;
    logic        finish;
    logic [11:0] full;
    logic [15:0] rem;
    logic [2:0]  k;

    phase_d = phase_q;
    field_d = field_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    over_d  = over_q;
    port_d  = port_q;
    inv_d   = inv_q;
    finish  = 1'b0;
    oct_we  = 1'b0;
    oct_idx = field_q[1:0];
    res_ok  = 1'b0;
    res_data = '0;
    k       = field_q;
    rem     = '0;

    digit = (in_byte_q >= ChZero) && (in_byte_q <= ChNine);
    space = (in_byte_q == ChSpace) || ((in_byte_q >= ChTab) && (in_byte_q <= ChCr));
    full  = 12'(mag_q) * 12'd10 + 12'(in_byte_q - ChZero);

    unique case (phase_q)
      PH_SEARCH: begin
        if (in_byte_q == ChOpen) begin
          phase_d = PH_START;
        end else if (in_byte_q == ChNul) begin
          phase_d = PH_FAIL;
        end
      end
      PH_START: begin
        if (space) begin
          phase_d = PH_START;
        end else if (in_byte_q == ChPlus || in_byte_q == ChMinus) begin
          neg_d   = (in_byte_q == ChMinus);
          phase_d = PH_SIGN;
        end else if (digit) begin
          over_d  = over_q || (full > 12'd255);
          mag_d   = full[7:0];
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_FAIL;
        end
      end
      PH_SIGN: begin
        if (digit) begin
          over_d  = over_q || (full > 12'd255);
          mag_d   = full[7:0];
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_FAIL;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          over_d = over_q || (full > 12'd255);
          mag_d  = full[7:0];
        end else if (field_q >= PortLoIdx || in_byte_q == ChComma) begin
          finish = 1'b1;
        end else begin
          phase_d = PH_FAIL;
        end
      end
      PH_DONE: phase_d = PH_DONE;
      default: phase_d = PH_FAIL;
    endcase

    // a sixth number still running at end of line counts as complete
    if (in_last_q && phase_d == PH_DIGITS && field_q >= PortLoIdx) begin
      finish = 1'b1;
    end

    if (finish) begin
      k   = field_q;
      rem = neg_d ? (16'd0 - 16'(mag_d)) : 16'(mag_d);
      if (k <= LastOctet) begin
        oct_we  = 1'b1;
        oct_idx = k[1:0];
        if (over_d || (neg_d && mag_d != 8'd0)) begin
          inv_d = 1'b1;
        end
      end else if (k == PortHiIdx) begin
        port_d = {rem[7:0], 8'd0};
      end else begin
        port_d = port_q + rem;
      end
      neg_d  = 1'b0;
      mag_d  = '0;
      over_d = 1'b0;
      if (k >= PortLoIdx) begin
        phase_d = PH_DONE;
      end else begin
        field_d = k + 3'd1;
        phase_d = PH_START;
      end
    end

    if (phase_d == PH_DONE) begin
      res_ok = 1'b1;
      res_data[OutW-1:AddrW] = port_d;
      if (inv_d) begin
        res_data[AddrW-1:0] = '1;
      end else begin
        // the fourth octet is stored on an earlier beat, so its bypass never selects here
        res_data[AddrW-1:0] = {octet_q[0], octet_q[1], octet_q[2],
                               (oct_we && oct_idx == 2'd3) ? mag_q : octet_q[3]};
      end
    end

    // clear for the next line after the final byte
    if (in_last_q) begin
      phase_d = PH_SEARCH;
      field_d = '0;
      neg_d   = 1'b0;
      mag_d   = '0;
      over_d  = 1'b0;
      port_d  = '0;
      inv_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_SEARCH;
      field_q   <= '0;
      neg_q     <= 1'b0;
      mag_q     <= '0;
      over_q    <= 1'b0;
      port_q    <= '0;
      inv_q     <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        phase_q <= phase_d;
        field_q <= field_d;
        neg_q   <= neg_d;
        mag_q   <= mag_d;
        over_q  <= over_d;
        port_q  <= port_d;
        inv_q   <= inv_d;
      end
      if (advance && in_last_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && oct_we) begin
      octet_q[oct_idx] <= mag_q;
    end
    if (advance && in_last_q) begin
      out_ok_q   <= res_ok;
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_ok_q;

endmodule

/* design/pasv_checker.sv */
// Port-level checker for the passive-mode reply parser, bound to the top level.
module pasv_checker
  import pasv_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid_i,
  input logic            s_axis_tready_o,
  input logic            m_axis_tvalid_o,
  input logic            m_axis_tready_i,
  input logic [OutW-1:0] m_axis_tdata_o,
  input logic            m_axis_tuser_o
);

  // input may only stall behind a result beat that is itself stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a blocked result beat");

  // a failed parse carries an all-zero payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("failed parse with nonzero payload");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      ($stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result beat changed while stalled");

endmodule

bind pasv_reply_address_parser_top pasv_checker u_pasv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
